// ===== src/xor_checked_frame_parser_defines.svh =====
// Assertion helpers included by the parser top level.
`ifndef XOR_CHECKED_FRAME_PARSER_DEFINES_SVH
`define XOR_CHECKED_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define XCFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define XCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/xcfp_pkg.sv =====
package xcfp_pkg;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEP   = 8'h2C;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int NUM_NAMES = 4;
	localparam int NAME_LEN  = 5;

	// CPERR, TMSCT, TMSTA, TMSVR
	localparam logic [7:0] NAME_CHARS [NUM_NAMES][NAME_LEN] = '{
		'{8'h43, 8'h50, 8'h45, 8'h52, 8'h52},
		'{8'h54, 8'h4D, 8'h53, 8'h43, 8'h54},
		'{8'h54, 8'h4D, 8'h53, 8'h54, 8'h41},
		'{8'h54, 8'h4D, 8'h53, 8'h56, 8'h52}
	};

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_HEADER,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_PCOMMA,
		PH_STAR,
		PH_HEX1,
		PH_HEX2,
		PH_CR,
		PH_LF
	} phase_t;

	typedef enum logic [2:0] {
		HT_EMPTY,
		HT_CPERR,
		HT_TMSCT,
		HT_TMSTA,
		HT_TMSVR,
		HT_OTHER
	} hdr_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_LEN,
		ST_NO_PCOMMA,
		ST_NO_STAR,
		ST_CSUM,
		ST_BAD_END
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD,
		KIND_REPORT
	} kind_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		hdr_t        header_type;
		logic [15:0] frame_length;
		status_t     frame_status;
		logic [7:0]  received_checksum;
		logic [7:0]  computed_checksum;
	} result_t;

	// Bit 4 flags a legal hex digit; low nibble is its value (zero if illegal).
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

// ===== src/xcfp_core.sv =====
module xcfp_core #(
	parameter int LENGTH_BITS       = 16,
	parameter int MAX_LENGTH_DIGITS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              has_result,
	output xcfp_pkg::result_t result
);

	localparam int DCNT_W = $clog2(MAX_LENGTH_DIGITS + 1);
	localparam logic [DCNT_W-1:0] DCNT_MAX = DCNT_W'(MAX_LENGTH_DIGITS);
	localparam int LX_W = LENGTH_BITS + 4;

	xcfp_pkg::phase_t        phase_q, phase_d;
	logic [2:0]              seen_q, seen_d;
	logic [3:0]              flags_q, flags_d;
	logic [LENGTH_BITS-1:0]  len_q, len_d;
	logic [DCNT_W-1:0]       dcnt_q, dcnt_d;
	logic [LENGTH_BITS-1:0]  pcnt_q, pcnt_d;
	logic [7:0]              xor_q, xor_d;
	logic [7:0]              csd_q, csd_d;
	xcfp_pkg::status_t       pend_q, pend_d;

	xcfp_pkg::hdr_t          hdr_class;
	logic [7:0]              nx;
	logic                    is_digit;
	logic [LX_W-1:0]         len_ext;
	logic [LX_W-1:0]         len_x10;
	logic                    len_ok;
	logic [LENGTH_BITS:0]    pcnt_inc;
	logic                    pay_last;
	logic [4:0]              hex;
	logic [7:0]              csd_new;
	logic [15:0]             len16;

	assign nx       = xor_q ^ rx_byte;
	assign is_digit = (rx_byte >= xcfp_pkg::CH_ZERO) && (rx_byte <= xcfp_pkg::CH_NINE);
	assign len_ext  = LX_W'(len_q);
	// value * 10 + digit, with four spare bits to spot overflow
	assign len_x10  = (len_ext << 3) + (len_ext << 1) + LX_W'(is_digit ? rx_byte[3:0] : 4'd0);
	assign len_ok   = is_digit && (dcnt_q < DCNT_MAX) && (len_x10[LX_W-1:LENGTH_BITS] == 4'd0);
	assign pcnt_inc = {1'b0, pcnt_q} + 1'b1;
	assign pay_last = pcnt_inc >= {1'b0, len_q};
	assign hex      = xcfp_pkg::hex_digit(rx_byte);
	assign csd_new  = {csd_q[3:0], hex[3:0]};
	assign len16    = 16'(len_q);

	always_comb begin
		if (seen_q == 3'd0) begin
			hdr_class = xcfp_pkg::HT_EMPTY;
		end else if (seen_q != 3'(xcfp_pkg::NAME_LEN)) begin
			hdr_class = xcfp_pkg::HT_OTHER;
		end else begin
			priority if (flags_q[0]) hdr_class = xcfp_pkg::HT_CPERR;
			else if (flags_q[1]) hdr_class = xcfp_pkg::HT_TMSCT;
			else if (flags_q[2]) hdr_class = xcfp_pkg::HT_TMSTA;
			else if (flags_q[3]) hdr_class = xcfp_pkg::HT_TMSVR;
			else hdr_class = xcfp_pkg::HT_OTHER;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			xcfp_pkg::PH_HUNT: begin
				if (rx_byte == xcfp_pkg::CH_START) phase_d = xcfp_pkg::PH_HEADER;
			end
			xcfp_pkg::PH_HEADER: begin
				if (rx_byte == xcfp_pkg::CH_SEP) phase_d = xcfp_pkg::PH_LENGTH;
			end
			xcfp_pkg::PH_LENGTH: begin
				if (rx_byte == xcfp_pkg::CH_SEP) begin
					phase_d = (len_q == '0) ? xcfp_pkg::PH_PCOMMA : xcfp_pkg::PH_PAYLOAD;
				end else if (!len_ok) begin
					phase_d = xcfp_pkg::PH_HUNT;
				end
			end
			xcfp_pkg::PH_PAYLOAD: begin
				if (pay_last) phase_d = xcfp_pkg::PH_PCOMMA;
			end
			xcfp_pkg::PH_PCOMMA: begin
				phase_d = (rx_byte == xcfp_pkg::CH_SEP) ? xcfp_pkg::PH_STAR : xcfp_pkg::PH_HUNT;
			end
			xcfp_pkg::PH_STAR: begin
				phase_d = (rx_byte == xcfp_pkg::CH_STAR) ? xcfp_pkg::PH_HEX1 : xcfp_pkg::PH_HUNT;
			end
			xcfp_pkg::PH_HEX1: phase_d = xcfp_pkg::PH_HEX2;
			xcfp_pkg::PH_HEX2: phase_d = xcfp_pkg::PH_CR;
			xcfp_pkg::PH_CR: begin
				phase_d = (rx_byte == xcfp_pkg::CH_CR) ? xcfp_pkg::PH_LF : xcfp_pkg::PH_HUNT;
			end
			xcfp_pkg::PH_LF: phase_d = xcfp_pkg::PH_HUNT;
			default: phase_d = xcfp_pkg::PH_HUNT;
		endcase
	end

	// datapath and results
	always_comb begin
		seen_d  = seen_q;
		flags_d = flags_q;
		len_d   = len_q;
		dcnt_d  = dcnt_q;
		pcnt_d  = pcnt_q;
		xor_d   = xor_q;
		csd_d   = csd_q;
		pend_d  = pend_q;

		has_result               = 1'b0;
		result.result_kind       = xcfp_pkg::KIND_REPORT;
		result.payload_byte      = 8'd0;
		result.payload_index     = 16'd0;
		result.header_type       = hdr_class;
		result.frame_length      = len16;
		result.frame_status      = xcfp_pkg::ST_OK;
		result.received_checksum = 8'd0;
		result.computed_checksum = xor_q;

		unique case (phase_q)
			xcfp_pkg::PH_HUNT: begin
				if (rx_byte == xcfp_pkg::CH_START) begin
					seen_d  = '0;
					flags_d = '1;
					len_d   = '0;
					dcnt_d  = '0;
					pcnt_d  = '0;
					xor_d   = '0;
					csd_d   = '0;
					pend_d  = xcfp_pkg::ST_OK;
				end
			end
			xcfp_pkg::PH_HEADER: begin
				xor_d = nx;
				if (rx_byte != xcfp_pkg::CH_SEP) begin
					if (seen_q < 3'(xcfp_pkg::NAME_LEN)) begin
						for (int k = 0; k < xcfp_pkg::NUM_NAMES; k++) begin
							if (xcfp_pkg::NAME_CHARS[k][seen_q] != rx_byte) flags_d[k] = 1'b0;
						end
					end else begin
						flags_d = '0;
					end
					if (seen_q != 3'd7) seen_d = seen_q + 3'd1;
				end
			end
			xcfp_pkg::PH_LENGTH: begin
				if (rx_byte == xcfp_pkg::CH_SEP) begin
					xor_d  = nx;
					pcnt_d = '0;
				end else if (len_ok) begin
					xor_d  = nx;
					len_d  = len_x10[LENGTH_BITS-1:0];
					dcnt_d = dcnt_q + 1'b1;
				end else begin
					has_result          = 1'b1;
					result.frame_status = xcfp_pkg::ST_BAD_LEN;
				end
			end
			xcfp_pkg::PH_PAYLOAD: begin
				xor_d                    = nx;
				pcnt_d                   = pcnt_inc[LENGTH_BITS-1:0];
				has_result               = 1'b1;
				result.result_kind       = xcfp_pkg::KIND_PAYLOAD;
				result.payload_byte      = rx_byte;
				result.payload_index     = 16'(pcnt_q);
				result.computed_checksum = 8'd0;
			end
			xcfp_pkg::PH_PCOMMA: begin
				if (rx_byte == xcfp_pkg::CH_SEP) begin
					xor_d = nx;
				end else begin
					has_result          = 1'b1;
					result.frame_status = xcfp_pkg::ST_NO_PCOMMA;
				end
			end
			xcfp_pkg::PH_STAR: begin
				if (rx_byte == xcfp_pkg::CH_STAR) begin
					pend_d = xcfp_pkg::ST_OK;
					csd_d  = '0;
				end else begin
					has_result          = 1'b1;
					result.frame_status = xcfp_pkg::ST_NO_STAR;
				end
			end
			xcfp_pkg::PH_HEX1: begin
				csd_d = csd_new;
				if (!hex[4]) pend_d = xcfp_pkg::ST_CSUM;
			end
			xcfp_pkg::PH_HEX2: begin
				csd_d = csd_new;
				if (!hex[4] || csd_new != xor_q) pend_d = xcfp_pkg::ST_CSUM;
			end
			xcfp_pkg::PH_CR: begin
				if (rx_byte != xcfp_pkg::CH_CR) begin
					has_result               = 1'b1;
					result.frame_status      = xcfp_pkg::ST_BAD_END;
					result.received_checksum = csd_q;
				end
			end
			xcfp_pkg::PH_LF: begin
				has_result               = 1'b1;
				result.received_checksum = csd_q;
				result.frame_status      = (rx_byte != xcfp_pkg::CH_LF) ?
					xcfp_pkg::ST_BAD_END : pend_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xcfp_pkg::PH_HUNT;
			seen_q  <= '0;
			flags_q <= '1;
			len_q   <= '0;
			dcnt_q  <= '0;
			pcnt_q  <= '0;
			xor_q   <= '0;
			csd_q   <= '0;
			pend_q  <= xcfp_pkg::ST_OK;
		end else if (step) begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			flags_q <= flags_d;
			len_q   <= len_d;
			dcnt_q  <= dcnt_d;
			pcnt_q  <= pcnt_d;
			xor_q   <= xor_d;
			csd_q   <= csd_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ===== src/xor_checked_frame_parser.sv =====
// Byte-serial deframer for '$' HEADER ',' LENGTH ',' DATA ',' '*' HH CR LF.
// Input channel rx_valid/rx_ready carries one received byte per request.
// Output channel res_valid/res_ready carries one result per request: either
// a payload byte (result_kind 0) with its index, or an end-of-frame report
// (result_kind 1) with header type, length, status and both checksums.
// Bytes outside a frame and most frame bytes produce no result.
// A byte is held in the input register, then a parse step moves its result
// into the result register. Throughput: one byte per cycle while the
// receiver keeps up; the parse state machine advances once per byte and the
// result register frees each cycle the receiver takes it.
// A stalled receiver holds the result; one more byte waits in the input
// register and rx_ready drops until the result is taken.
// Reset (arst_n low) empties both registers and returns the parser to
// hunting for '$'.
module xor_checked_frame_parser #(
	parameter int LENGTH_BITS       = 16,
	parameter int MAX_LENGTH_DIGITS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic [2:0]  header_type,
	output logic [15:0] frame_length,
	output logic [2:0]  frame_status,
	output logic [7:0]  received_checksum,
	output logic [7:0]  computed_checksum
);

	`include "xor_checked_frame_parser_defines.svh"

	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              adv;
	logic              has_res;
	xcfp_pkg::result_t res;
	logic              res_valid_q;
	xcfp_pkg::result_t res_q;

	logic              pay_out;
	logic              rep_out;
	logic              rep_zero;
	logic              pay_zero;
	logic              res_new;

	// advance the held byte once the result register is free or being drained
	assign adv      = v_s1 && (!res_valid_q || res_ready);
	assign rx_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx_ready) begin
			v_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) byte_s1 <= rx_byte;
	end

	xcfp_core #(
		.LENGTH_BITS       (LENGTH_BITS),
		.MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.rx_byte    (byte_s1),
		.has_result (has_res),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= has_res;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) res_q <= res;
	end

	assign res_valid         = res_valid_q;
	assign result_kind       = res_q.result_kind;
	assign payload_byte      = res_q.payload_byte;
	assign payload_index     = res_q.payload_index;
	assign header_type       = res_q.header_type;
	assign frame_length      = res_q.frame_length;
	assign frame_status      = res_q.frame_status;
	assign received_checksum = res_q.received_checksum;
	assign computed_checksum = res_q.computed_checksum;

	assign pay_out  = res_valid_q && (res_q.result_kind == xcfp_pkg::KIND_PAYLOAD);
	assign rep_out  = res_valid_q && (res_q.result_kind == xcfp_pkg::KIND_REPORT);
	assign rep_zero = (res_q.frame_status == xcfp_pkg::ST_OK) &&
		(res_q.received_checksum == 8'd0) && (res_q.computed_checksum == 8'd0);
	assign pay_zero = (res_q.payload_byte == 8'd0) && (res_q.payload_index == 16'd0);
	assign res_new  = adv && has_res;

	`XCFP_ASSERT_SAME(a_payload_clean, clk, arst_n, pay_out, rep_zero, "report fields on payload")
	`XCFP_ASSERT_SAME(a_report_clean, clk, arst_n, rep_out, pay_zero, "payload fields on report")
	`XCFP_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !res_valid_q, rx_ready, "stall, output empty")
	`XCFP_ASSERT_NEXT(a_result_lands, clk, arst_n, res_new, res_valid_q, "result not registered")

endmodule

// ===== bench/xor_checked_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module xor_checked_frame_parser_tb;

	localparam int LEN_BITS   = 16;
	localparam int MAX_DIGITS = 5;
	localparam int LEN_MAX    = (1 << LEN_BITS) - 1;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [2:0]  header_type;
	logic [15:0] frame_length;
	logic [2:0]  frame_status;
	logic [7:0]  received_checksum;
	logic [7:0]  computed_checksum;

	xor_checked_frame_parser #(
		.LENGTH_BITS(LEN_BITS),
		.MAX_LENGTH_DIGITS(MAX_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.result_kind(result_kind),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.header_type(header_type),
		.frame_length(frame_length),
		.frame_status(frame_status),
		.received_checksum(received_checksum),
		.computed_checksum(computed_checksum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting to be sent and results the parser still owes.
	logic [7:0]          rx_pending[$];
	xcfp_pkg::result_t   due_results[$];
	int                  bytes_queued = 0;
	int                  mismatches = 0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	logic                res_hold = 1'b0;
	logic                rx_took = 1'b0;

	// Deframer state as seen from outside.
	xcfp_pkg::phase_t    parse_phase = xcfp_pkg::PH_HUNT;
	logic [2:0]          hdr_seen = '0;
	logic [3:0]          hdr_flags = 4'hF;
	int                  len_acc = 0;
	int                  len_digits = 0;
	int                  pay_cnt = 0;
	logic [7:0]          run_xor = '0;
	logic [7:0]          cs_digits = '0;
	xcfp_pkg::status_t   pend_status = xcfp_pkg::ST_OK;

	function automatic xcfp_pkg::hdr_t header_class();
		if (hdr_seen == 3'd0) return xcfp_pkg::HT_EMPTY;
		if (hdr_seen != 3'd5) return xcfp_pkg::HT_OTHER;
		for (int k = 0; k < xcfp_pkg::NUM_NAMES; k++) begin
			if (hdr_flags[k]) return xcfp_pkg::hdr_t'(k + 1);
		end
		return xcfp_pkg::HT_OTHER;
	endfunction

	function automatic int hex_value(input logic [7:0] c);
		if (c >= xcfp_pkg::CH_ZERO && c <= xcfp_pkg::CH_NINE)
			return int'(c) - int'(xcfp_pkg::CH_ZERO);
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	function automatic void close_frame(input xcfp_pkg::status_t st, input logic [7:0] rx_cs);
		xcfp_pkg::result_t r;
		r = '0;
		r.result_kind = xcfp_pkg::KIND_REPORT;
		r.header_type = header_class();
		r.frame_length = 16'(len_acc);
		r.frame_status = st;
		r.received_checksum = rx_cs;
		r.computed_checksum = run_xor;
		due_results = {due_results, r};
		parse_phase = xcfp_pkg::PH_HUNT;
	endfunction

	function automatic void track_frame_byte(input logic [7:0] c);
		logic [7:0]        nx;
		int                h;
		xcfp_pkg::result_t r;
		nx = run_xor ^ c;
		case (parse_phase)
			xcfp_pkg::PH_HUNT: begin
				if (c == xcfp_pkg::CH_START) begin
					hdr_seen = '0;
					hdr_flags = 4'hF;
					len_acc = 0;
					len_digits = 0;
					pay_cnt = 0;
					run_xor = '0;
					cs_digits = '0;
					pend_status = xcfp_pkg::ST_OK;
					parse_phase = xcfp_pkg::PH_HEADER;
				end
			end
			xcfp_pkg::PH_HEADER: begin
				run_xor = nx;
				if (c == xcfp_pkg::CH_SEP) begin
					parse_phase = xcfp_pkg::PH_LENGTH;
				end else begin
					if (hdr_seen < 3'd5) begin
						for (int k = 0; k < xcfp_pkg::NUM_NAMES; k++) begin
							if (xcfp_pkg::NAME_CHARS[k][hdr_seen] != c) hdr_flags[k] = 1'b0;
						end
					end else begin
						hdr_flags = '0;
					end
					if (hdr_seen < 3'd7) hdr_seen++;
				end
			end
			xcfp_pkg::PH_LENGTH: begin
				if (c == xcfp_pkg::CH_SEP) begin
					run_xor = nx;
					pay_cnt = 0;
					parse_phase = (len_acc == 0) ? xcfp_pkg::PH_PCOMMA : xcfp_pkg::PH_PAYLOAD;
				end else if (c >= xcfp_pkg::CH_ZERO && c <= xcfp_pkg::CH_NINE &&
						len_digits < MAX_DIGITS &&
						len_acc * 10 + int'(c - xcfp_pkg::CH_ZERO) <= LEN_MAX) begin
					run_xor = nx;
					len_acc = len_acc * 10 + int'(c - xcfp_pkg::CH_ZERO);
					len_digits++;
				end else begin
					close_frame(xcfp_pkg::ST_BAD_LEN, 8'h00);
				end
			end
			xcfp_pkg::PH_PAYLOAD: begin
				run_xor = nx;
				r = '0;
				r.result_kind = xcfp_pkg::KIND_PAYLOAD;
				r.payload_byte = c;
				r.payload_index = 16'(pay_cnt);
				r.header_type = header_class();
				r.frame_length = 16'(len_acc);
				r.frame_status = xcfp_pkg::ST_OK;
				due_results = {due_results, r};
				pay_cnt++;
				if (pay_cnt >= len_acc) parse_phase = xcfp_pkg::PH_PCOMMA;
			end
			xcfp_pkg::PH_PCOMMA: begin
				if (c != xcfp_pkg::CH_SEP) begin
					close_frame(xcfp_pkg::ST_NO_PCOMMA, 8'h00);
				end else begin
					run_xor = nx;
					parse_phase = xcfp_pkg::PH_STAR;
				end
			end
			xcfp_pkg::PH_STAR: begin
				if (c != xcfp_pkg::CH_STAR) begin
					close_frame(xcfp_pkg::ST_NO_STAR, 8'h00);
				end else begin
					pend_status = xcfp_pkg::ST_OK;
					cs_digits = '0;
					parse_phase = xcfp_pkg::PH_HEX1;
				end
			end
			xcfp_pkg::PH_HEX1, xcfp_pkg::PH_HEX2: begin
				h = hex_value(c);
				// an illegal digit counts as zero but spoils the frame
				if (h < 0) begin
					pend_status = xcfp_pkg::ST_CSUM;
					h = 0;
				end
				cs_digits = {cs_digits[3:0], 4'(h)};
				if (parse_phase == xcfp_pkg::PH_HEX2) begin
					if (cs_digits != run_xor) pend_status = xcfp_pkg::ST_CSUM;
					parse_phase = xcfp_pkg::PH_CR;
				end else begin
					parse_phase = xcfp_pkg::PH_HEX2;
				end
			end
			xcfp_pkg::PH_CR: begin
				if (c != xcfp_pkg::CH_CR) close_frame(xcfp_pkg::ST_BAD_END, cs_digits);
				else parse_phase = xcfp_pkg::PH_LF;
			end
			xcfp_pkg::PH_LF: begin
				if (c != xcfp_pkg::CH_LF) close_frame(xcfp_pkg::ST_BAD_END, cs_digits);
				else close_frame(pend_status, cs_digits);
			end
			default: parse_phase = xcfp_pkg::PH_HUNT;
		endcase
	endfunction

	function automatic string show_result(input xcfp_pkg::result_t r);
		return $sformatf("kind=%0d byte=%02h idx=%0d hdr=%0d len=%0d st=%0d rxcs=%02h cs=%02h",
			r.result_kind, r.payload_byte, r.payload_index, r.header_type,
			r.frame_length, r.frame_status, r.received_checksum, r.computed_checksum);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) return xcfp_pkg::CH_ZERO + 8'(n);
		return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic byte_q_t text_bytes(input string s);
		byte_q_t t;
		t = {};
		for (int i = 0; i < s.len(); i++) t = {t, 8'(s[i])};
		return t;
	endfunction

	function automatic byte_q_t decimal_text(input int v, input bit lead_zero);
		byte_q_t t;
		t = {};
		do begin
			t.push_front(xcfp_pkg::CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v > 0);
		if (lead_zero) t.push_front(xcfp_pkg::CH_ZERO);
		return t;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		rx_pending = {rx_pending, b};
		bytes_queued++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
	endtask

	// Build one frame with a random payload and its checksum; optionally spoil
	// the checksum or overwrite one byte after the start marker.
	task automatic queue_frame(input byte_q_t hdr, input byte_q_t len_txt, input int pay_len,
			input bit lower, input bit spoil, input bit corrupt);
		byte_q_t    f;
		logic [7:0] x;
		f = {};
		f = {f, xcfp_pkg::CH_START};
		for (int i = 0; i < hdr.size(); i++) f = {f, hdr[i]};
		f = {f, xcfp_pkg::CH_SEP};
		for (int i = 0; i < len_txt.size(); i++) f = {f, len_txt[i]};
		f = {f, xcfp_pkg::CH_SEP};
		repeat (pay_len) f = {f, 8'($urandom_range(255))};
		f = {f, xcfp_pkg::CH_SEP};
		x = '0;
		for (int i = 1; i < f.size(); i++) x ^= f[i];
		if (spoil) x ^= 8'(1 << $urandom_range(7));
		f = {f, xcfp_pkg::CH_STAR};
		f = {f, hex_char(x[7:4], lower)};
		f = {f, hex_char(x[3:0], lower)};
		f = {f, xcfp_pkg::CH_CR};
		f = {f, xcfp_pkg::CH_LF};
		if (corrupt) f[$urandom_range(1, f.size() - 1)] = 8'($urandom_range(255));
		for (int i = 0; i < f.size(); i++) push_byte(f[i]);
	endtask

	task automatic queue_random_frame();
		byte_q_t    hdr;
		byte_q_t    len_txt;
		int         pick;
		int         len;
		logic [7:0] b;
		hdr = {};
		len_txt = {};
		// line noise between frames
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(255));
				if (b != xcfp_pkg::CH_START) push_byte(b);
			end
		end
		pick = $urandom_range(11);
		if (pick < 8) begin
			for (int i = 0; i < xcfp_pkg::NAME_LEN; i++)
				hdr = {hdr, xcfp_pkg::NAME_CHARS[pick % xcfp_pkg::NUM_NAMES][i]};
		end else if (pick == 9) begin
			// near miss on a known name
			for (int i = 0; i < xcfp_pkg::NAME_LEN; i++)
				hdr = {hdr, xcfp_pkg::NAME_CHARS[$urandom_range(3)][i]};
			hdr[$urandom_range(xcfp_pkg::NAME_LEN - 1)] ^= 8'h01;
		end else if (pick > 9) begin
			repeat ($urandom_range(1, 8)) begin
				b = 8'($urandom_range(255));
				if (b == xcfp_pkg::CH_SEP) b = xcfp_pkg::CH_START;
				hdr = {hdr, b};
			end
		end
		pick = $urandom_range(19);
		if (pick == 0) len = 0;
		else if (pick < 17) len = $urandom_range(0, 12);
		else len = $urandom_range(13, 48);
		if (pick != 0) len_txt = decimal_text(len, $urandom_range(4) == 0);
		queue_frame(hdr, len_txt, len, 1'($urandom_range(1)), $urandom_range(9) == 0,
			$urandom_range(5) == 0);
	endtask

	// Sender and receiver: change inputs on the falling edge only.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!rx_valid || rx_took) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_valid <= 1'b1;
					rx_byte <= rx_pending.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
			res_ready <= !res_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Predict on every accepted byte, check every taken result.
	always @(posedge clk) begin
		xcfp_pkg::result_t got;
		xcfp_pkg::result_t want;
		rx_took <= rx_valid && rx_ready;
		if (arst_n) begin
			if (rx_valid && rx_ready) track_frame_byte(rx_byte);
			if (res_valid && res_ready) begin
				got.result_kind = xcfp_pkg::kind_t'(result_kind);
				got.payload_byte = payload_byte;
				got.payload_index = payload_index;
				got.header_type = xcfp_pkg::hdr_t'(header_type);
				got.frame_length = frame_length;
				got.frame_status = xcfp_pkg::status_t'(frame_status);
				got.received_checksum = received_checksum;
				got.computed_checksum = computed_checksum;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t want: none, got: %s", $realtime, show_result(got));
				end else begin
					want = due_results.pop_front();
					if (got.result_kind !== want.result_kind ||
							got.payload_byte !== want.payload_byte ||
							got.payload_index !== want.payload_index ||
							got.header_type !== want.header_type ||
							got.frame_length !== want.frame_length ||
							got.frame_status !== want.frame_status ||
							got.received_checksum !== want.received_checksum ||
							got.computed_checksum !== want.computed_checksum) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t mismatch want: %s", $realtime, show_result(want));
							$display("%0t          got:  %s", $realtime, show_result(got));
						end
					end
				end
			end
		end
	end

	// Long receiver hold-off early on, while the sender keeps pushing bytes.
	initial begin
		wait (arst_n);
		repeat (30) @(posedge clk);
		res_hold = 1'b1;
		repeat (400) @(posedge clk);
		res_hold = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL xor_checked_frame_parser");
		$finish;
	end

	initial begin
		int target;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// bytes seen while hunting
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(xcfp_pkg::CH_LF);
		queue_frame(text_bytes("TMSVR"), text_bytes("3"), 3, 1'b0, 1'b0, 1'b0);
		queue_frame(text_bytes(""), text_bytes(""), 0, 1'b0, 1'b0, 1'b0);
		queue_frame(text_bytes("CPERR"), text_bytes("2"), 2, 1'b1, 1'b0, 1'b0);
		queue_frame(text_bytes("TMSCT"), text_bytes("12"), 12, 1'b0, 1'b0, 1'b0);
		queue_frame(text_bytes("TMSTA"), text_bytes("1"), 1, 1'b1, 1'b1, 1'b0);
		queue_frame(text_bytes("TMSCTX"), text_bytes("0"), 0, 1'b0, 1'b0, 1'b0);
		queue_frame(text_bytes("TMS"), text_bytes("1"), 1, 1'b0, 1'b0, 1'b0);
		queue_frame(text_bytes("GPGGA"), decimal_text(260, 1'b1), 260, 1'b1, 1'b0, 1'b0);
		// length errors (too many digits, overflow, non-digit), then trailer errors
		queue_text("$A,655359");
		queue_text("$A,65536");
		queue_text("$A,1x");
		queue_text("$A,1,Q;");
		queue_text("$A,,;");
		queue_text("$A,,,#");
		queue_text("$A,,,*G0");
		push_byte(xcfp_pkg::CH_CR);
		push_byte(xcfp_pkg::CH_LF);
		queue_text("$A,,,*00X");
		queue_text("$A,,,*00");
		push_byte(xcfp_pkg::CH_CR);
		queue_text("X");

		for (int m = 0; m < 4; m++) begin
			@(posedge clk);
			send_idle_pct = (m == 1) ? 57 : (m == 3) ? 38 : 0;
			recv_stall_pct = (m == 2) ? 57 : (m == 3) ? 38 : 0;
			target = bytes_queued + 30;
			while (bytes_queued < target) queue_random_frame();
			while (rx_pending.size() != 0 || rx_valid || due_results.size() != 0)
				@(negedge clk);
		end

		repeat (20) @(negedge clk);
		if (due_results.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("PASS xor_checked_frame_parser");
		end else begin
			$display("FAIL xor_checked_frame_parser");
		end
		$finish;
	end

endmodule
